>>> hdl/pixel_art_scale_2x_3x_defines.svh
// assertion macros shared by the pixel art scaler rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef PIXEL_ART_SCALE_2X_3X_DEFINES_SVH
`define PIXEL_ART_SCALE_2X_3X_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define PAS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/pas_pkg.sv
// shared types and constants of the pixel art scaler
// no dependencies; used by the front end, the emitter and the top level
package pas_pkg;

   // widest source coordinate held in a job (positions stay below 4096)
   localparam int POS_W = 12;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [8:0]       idx_type;
   typedef logic [2:0][2:0][8:0] win_type;   // [row][col] of palette indices

   // register indexes of the configuration port
   localparam logic [2:0] CSR_SCALE_FACTOR = 3'd0;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_COL_START    = 3'd2;
   localparam logic [2:0] CSR_COL_END      = 3'd3;
   localparam logic [2:0] CSR_ROW_START    = 3'd4;
   localparam logic [2:0] CSR_ROW_END      = 3'd5;

   typedef struct packed {
      logic [1:0] scale_factor;
      logic [9:0] frame_width;
      logic [8:0] col_start;
      logic [9:0] col_end;
      logic [8:0] row_start;
      logic [9:0] row_end;
   } cfg_type;

   // one retired input beat handed from the front end to the emitter
   typedef struct packed {
      logic        pal_write;   // palette write rather than a pixel
      idx_type     index;       // palette address of a write
      logic [31:0] color;
      win_type     win;         // neighbour window after this pixel
      pos_type     col;         // column of this pixel
      pos_type     row;         // row of this pixel
      logic [1:0]  row_mask;    // [0] row above is a centre row, [1] this row is
      logic [1:0]  col_mask;    // [0] column left is a centre column, [1] this one is
   } job_type;

endpackage

>>> hdl/pas_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pas_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pas_front.sv
// front end: raster position, two line stores and the 3x3 neighbour window
// depends on pas_pkg and pas_ram
module pas_front #(
   parameter int LINE_WIDTH = 512,
   parameter int MAX_ROWS   = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  pas_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_mode,
   input  logic              in_frame_start,
   input  pas_pkg::idx_type  in_index,
   input  logic [31:0]       in_color,
   output logic              job_valid,
   input  logic              job_ready,
   output pas_pkg::job_type  job
);

   localparam int AW    = $clog2(LINE_WIDTH);
   localparam int COL_W = $clog2(LINE_WIDTH + 1);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int KB    = (COL_W > RW ? COL_W : RW) + 2;
   localparam int KW    = KB > 11 ? KB : 11;

   logic [COL_W-1:0] col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             ovf_ff, ovf_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pal_ff;
   pas_pkg::idx_type s1_idx_ff;
   logic [31:0]      s1_color_ff;
   logic [AW-1:0]    s1_c_ff;
   logic [RW-1:0]    s1_r_ff;
   logic             fwd_ff;
   pas_pkg::idx_type fwd_top_ff, fwd_idx_ff;
   pas_pkg::win_type win_ff, win_in;

   logic             accept, retire, drop, fwd_in;
   logic [KW-1:0]    fw, fw_raw;
   logic [COL_W-1:0] col0, col1, col2;
   logic [RW-1:0]    row0, row1;
   logic             ovf0, ovf1, wrap2, ovf3;
   pas_pkg::idx_type ram_top2, ram_top1, top2, top1;
   logic             ls_we;
   logic [KW-1:0]    rk, ck, rs, re, cs, ce;

   assign retire   = s1_valid_ff && job_ready;
   assign in_ready = !s1_valid_ff || retire;
   assign accept   = in_valid && in_ready;

   // effective row width: zero acts as one, clipped to the line store
   always_comb begin
      fw_raw = KW'(cfg.frame_width);
      if (fw_raw == '0) begin
         fw = KW'(1);
      end else if (fw_raw > KW'(LINE_WIDTH)) begin
         fw = KW'(LINE_WIDTH);
      end else begin
         fw = fw_raw;
      end
   end

   // raster position before and after this pixel
   always_comb begin
      col0  = in_frame_start ? '0 : col_ff;
      row0  = in_frame_start ? '0 : row_ff;
      ovf0  = in_frame_start ? 1'b0 : ovf_ff;
      col1  = col0;
      row1  = row0;
      ovf1  = ovf0;
      if (!ovf0 && KW'(col0) >= fw) begin
         col1 = '0;
         if (KW'(row0) + KW'(1) >= KW'(MAX_ROWS)) begin
            ovf1 = 1'b1;
         end else begin
            row1 = row0 + RW'(1);
         end
      end
      drop   = ovf1;
      col2   = col1 + COL_W'(1);
      wrap2  = KW'(col2) >= fw;
      ovf3   = KW'(row1) + KW'(1) >= KW'(MAX_ROWS);
      col_in = col_ff;
      row_in = row_ff;
      ovf_in = ovf_ff;
      if (accept && !in_mode) begin
         if (drop) begin
            col_in = col1;
            row_in = row1;
            ovf_in = ovf1;
         end else if (wrap2) begin
            col_in = '0;
            ovf_in = ovf3;
            row_in = ovf3 ? row1 : row1 + RW'(1);
         end else begin
            col_in = col2;
            row_in = row1;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ovf_ff <= ovf_in;
      end
   end

   // input register; dropped pixels never occupy it
   assign s1_valid_in = accept ? (in_mode || !drop) : (s1_valid_ff && !retire);
   assign fwd_in = retire && !s1_pal_ff && (s1_c_ff == col1[AW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pal_ff   <= in_mode;
         s1_idx_ff   <= in_index;
         s1_color_ff <= in_color;
         s1_c_ff     <= col1[AW-1:0];
         s1_r_ff     <= row1;
         fwd_ff      <= fwd_in;
         fwd_top_ff  <= top1;
         fwd_idx_ff  <= s1_idx_ff;
      end
   end

   // line stores: upper holds two rows up, lower holds the row above
   assign ls_we = retire && !s1_pal_ff;

   pas_ram #(.WIDTH(9), .DEPTH(LINE_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (s1_c_ff),
      .wr_data (top1),
      .rd_en   (accept),
      .rd_addr (col1[AW-1:0]),
      .rd_data (ram_top2)
   );

   pas_ram #(.WIDTH(9), .DEPTH(LINE_WIDTH)) u_line_lower (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (s1_c_ff),
      .wr_data (s1_idx_ff),
      .rd_en   (accept),
      .rd_addr (col1[AW-1:0]),
      .rd_data (ram_top1)
   );

   // bypass when the previous beat wrote the same column
   assign top2 = fwd_ff ? fwd_top_ff : ram_top2;
   assign top1 = fwd_ff ? fwd_idx_ff : ram_top1;

   // window shifts left by one column and takes the new column at the right
   always_comb begin
      win_in = win_ff;
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top2;
      win_in[1][2] = top1;
      win_in[2][2] = s1_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ls_we) begin
         win_ff <= win_in;
      end
   end

   // which centres this pixel completes
   always_comb begin
      rk = KW'(s1_r_ff);
      ck = KW'(s1_c_ff);
      rs = KW'(cfg.row_start);
      re = KW'(cfg.row_end);
      cs = KW'(cfg.col_start);
      ce = KW'(cfg.col_end);
      job.pal_write   = s1_pal_ff;
      job.index       = s1_idx_ff;
      job.color       = s1_color_ff;
      job.win         = win_in;
      job.col         = pas_pkg::pos_type'(s1_c_ff);
      job.row         = pas_pkg::pos_type'(s1_r_ff);
      job.row_mask[0] = rk >= KW'(1) && rk - KW'(1) >= rs && rk < re;
      job.row_mask[1] = rk >= rs && rk + KW'(1) == re;
      job.col_mask[0] = ck >= KW'(1) && ck - KW'(1) >= cs && ck < ce;
      job.col_mask[1] = ck >= cs && ck + KW'(1) == ce;
   end

   assign job_valid = s1_valid_ff;

endmodule

>>> hdl/pas_emit.sv
// emitter: walks the centres of a job, applies the scale2x / scale3x rules,
// looks up the palette and holds the result beat; depends on pas_pkg, pas_ram
`include "pixel_art_scale_2x_3x_defines.svh"

module pas_emit #(
   parameter int PALETTE_ENTRIES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  pas_pkg::cfg_type cfg,
   input  logic             job_valid,
   output logic             job_ready,
   input  pas_pkg::job_type job,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,   // out_x[10:0], out_y[21:11], out_color[53:22]
   output logic             rsp_tlast
);

   localparam int PAW = $clog2(PALETTE_ENTRIES);
   localparam int XW  = (PAW > 9 ? PAW : 9) + 1;
   localparam int EW  = pas_pkg::POS_W + 1;

   logic             busy_ff, busy_in;
   pas_pkg::win_type win_ff;
   pas_pkg::pos_type col_ff, row_ff;
   logic [1:0]       rm_ff, cm_ff;
   logic             rsel_ff, rsel_in, csel_ff, csel_in;
   logic [1:0]       i_ff, i_in, j_ff, j_in;

   logic             q_valid_ff, q_valid_in;
   logic [10:0]      q_x_ff, q_y_ff;
   logic             q_last_ff, q_zero_ff;

   logic             job_fire, scale_on, any, issue, sub_done, has_next, last_sub;
   logic             pal_we, pal_in_range, rd_in_range;
   logic [XW-1:0]    pal_wx, rd_x;
   logic [1:0]       f, wr, wc, ur, dr, lc, rc;
   pas_pkg::pos_type cr, cc;
   logic [EW-1:0]    re_x, ce_x;
   pas_pkg::idx_type a, b, c, d, e, fv, g, h, iv, pick;
   pas_pkg::idx_type e2 [4];
   pas_pkg::idx_type e3 [9];
   logic [3:0]       k;
   logic [10:0]      dx, dy, x, y;
   logic [31:0]      pal_rd;

   assign f         = cfg.scale_factor;
   assign scale_on  = (f == 2'd2) || (f == 2'd3);
   assign job_ready = !busy_ff;
   assign job_fire  = job_valid && !busy_ff;
   assign any       = scale_on && !job.pal_write && (|job.row_mask) && (|job.col_mask);
   assign issue     = busy_ff && (!q_valid_ff || rsp_tready);

   // palette writes only land while nothing is being looked up
   assign pal_wx       = XW'(job.index);
   assign pal_in_range = pal_wx < XW'(PALETTE_ENTRIES);
   assign pal_we       = job_fire && job.pal_write && pal_in_range;

   // current centre and its clamped neighbour rows and columns
   always_comb begin
      wr   = rsel_ff ? 2'd2 : 2'd1;
      wc   = csel_ff ? 2'd2 : 2'd1;
      cr   = rsel_ff ? row_ff : row_ff - pas_pkg::pos_type'(1);
      cc   = csel_ff ? col_ff : col_ff - pas_pkg::pos_type'(1);
      re_x = EW'(cfg.row_end);
      ce_x = EW'(cfg.col_end);
      ur   = (cr == '0) ? wr : wr - 2'd1;
      lc   = (cc == '0) ? wc : wc - 2'd1;
      dr   = (EW'(cr) + EW'(1) >= re_x || wr == 2'd2) ? wr : wr + 2'd1;
      rc   = (EW'(cc) + EW'(1) >= ce_x || wc == 2'd2) ? wc : wc + 2'd1;
      a    = win_ff[ur][lc];
      b    = win_ff[ur][wc];
      c    = win_ff[ur][rc];
      d    = win_ff[wr][lc];
      e    = win_ff[wr][wc];
      fv   = win_ff[wr][rc];
      g    = win_ff[dr][lc];
      h    = win_ff[dr][wc];
      iv   = win_ff[dr][rc];
   end

   // expansion rules on palette indices
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         e2[n] = e;
      end
      for (int n = 0; n < 9; n++) begin
         e3[n] = e;
      end
      if (b != h && d != fv) begin
         e2[0] = (d == b) ? d : e;
         e2[1] = (b == fv) ? fv : e;
         e2[2] = (d == h) ? d : e;
         e2[3] = (h == fv) ? fv : e;
         e3[0] = (d == b) ? d : e;
         e3[1] = ((d == b && e != c) || (b == fv && e != a)) ? b : e;
         e3[2] = (b == fv) ? fv : e;
         e3[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
         e3[5] = ((b == fv && e != iv) || (h == fv && e != c)) ? fv : e;
         e3[6] = (d == h) ? d : e;
         e3[7] = ((d == h && e != iv) || (h == fv && e != g)) ? h : e;
         e3[8] = (h == fv) ? fv : e;
      end
      if (f == 2'd2) begin
         k    = {2'b00, j_ff[0], i_ff[0]};
         pick = e2[k[1:0]];
      end else begin
         k    = 4'({j_ff, 1'b0}) + 4'(j_ff) + 4'(i_ff);
         pick = (k > 4'd8) ? e : e3[k];
      end
   end

   // destination coordinate, kept to eleven bits
   always_comb begin
      dx = 11'(cc) - 11'(cfg.col_start);
      dy = 11'(cr) - 11'(cfg.row_start);
      x  = 11'(dx * 11'(f)) + 11'(i_ff);
      y  = 11'(dy * 11'(f)) + 11'(j_ff);
   end

   // sequencing over subpixels, then columns, then rows
   always_comb begin
      sub_done = (i_ff + 2'd1 == f) && (j_ff + 2'd1 == f);
      has_next = (!csel_ff && cm_ff[1]) || (!rsel_ff && rm_ff[1]);
      last_sub = sub_done && !has_next;
      busy_in  = busy_ff;
      rsel_in  = rsel_ff;
      csel_in  = csel_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      if (job_fire) begin
         busy_in = any;
         rsel_in = !job.row_mask[0];
         csel_in = !job.col_mask[0];
         i_in    = 2'd0;
         j_in    = 2'd0;
      end else if (issue) begin
         if (i_ff + 2'd1 != f) begin
            i_in = i_ff + 2'd1;
         end else if (j_ff + 2'd1 != f) begin
            i_in = 2'd0;
            j_in = j_ff + 2'd1;
         end else begin
            i_in = 2'd0;
            j_in = 2'd0;
            if (!csel_ff && cm_ff[1]) begin
               csel_in = 1'b1;
            end else if (!rsel_ff && rm_ff[1]) begin
               rsel_in = 1'b1;
               csel_in = !cm_ff[0];
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rsel_ff <= rsel_in;
      csel_ff <= csel_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      if (job_fire) begin
         win_ff <= job.win;
         col_ff <= job.col;
         row_ff <= job.row;
         rm_ff  <= job.row_mask;
         cm_ff  <= job.col_mask;
      end
   end

   // palette lookup
   assign rd_x        = XW'(pick);
   assign rd_in_range = rd_x < XW'(PALETTE_ENTRIES);

   pas_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_wx[PAW-1:0]),
      .wr_data (job.color),
      .rd_en   (issue),
      .rd_addr (rd_x[PAW-1:0]),
      .rd_data (pal_rd)
   );

   // result register alongside the palette read data
   assign q_valid_in = issue ? 1'b1 : (q_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         q_x_ff    <= x;
         q_y_ff    <= y;
         q_last_ff <= last_sub;
         q_zero_ff <= !rd_in_range;
      end
   end

   assign rsp_tvalid = q_valid_ff;
   assign rsp_tlast  = q_last_ff;
   assign rsp_tdata  = {2'b00, (q_zero_ff ? 32'd0 : pal_rd), q_y_ff, q_x_ff};

   // palette write never overlaps a lookup sequence
   `PAS_ASSERT_NOW(a_pal_idle, clock, reset, pal_we, !busy_ff, "palette write while busy")
   // the final subpixel of a job ends the sequence
   `PAS_ASSERT_NEXT(a_last_ends, clock, reset, issue && last_sub, !busy_ff && rsp_tvalid,
      "sequence still running after last beat")
   // the walk only visits completed centres
   `PAS_ASSERT_NOW(a_valid_centre, clock, reset, busy_ff,
      rm_ff[rsel_ff] && cm_ff[csel_ff], "emitting an unselected centre")

endmodule

>>> hdl/pixel_art_scale_2x_3x.sv
// pixel_art_scale_2x_3x: an input beat passes the front end input register, the emitter's
// job registers and the result register before its first result beat. a pixel yields up to
// four centres of factor*factor beats each, one result beat per cycle from the single palette
// read port while rsp_tready does not hold the output. the emitter takes no new job until it
// has issued every beat of the last; palette and window writes retire once it is idle.
// synchronous active high reset clears position, window, control and registers; the
// line stores and palette are undefined until written, so there is no clearing pass.
module pixel_art_scale_2x_3x #(
   parameter int LINE_WIDTH      = 512,
   parameter int PALETTE_ENTRIES = 512,
   parameter int MAX_ROWS        = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pixel_index[8:0], palette_color[40:9]
   input  logic [1:0]  req_tuser,   // mode[0], frame_start[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_x[10:0], out_y[21:11], out_color[53:22]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   pas_pkg::cfg_type cfg_ff, cfg_in;
   pas_pkg::job_type job;
   logic             job_valid, job_ready;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pas_pkg::CSR_SCALE_FACTOR: cfg_in.scale_factor = csr_data[1:0];
            pas_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_data;
            pas_pkg::CSR_COL_START:    cfg_in.col_start    = csr_data[8:0];
            pas_pkg::CSR_COL_END:      cfg_in.col_end      = csr_data;
            pas_pkg::CSR_ROW_START:    cfg_in.row_start    = csr_data[8:0];
            pas_pkg::CSR_ROW_END:      cfg_in.row_end      = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_factor <= 2'd2;
         cfg_ff.frame_width  <= 10'd256;
         cfg_ff.col_start    <= 9'd0;
         cfg_ff.col_end      <= 10'd256;
         cfg_ff.row_start    <= 9'd0;
         cfg_ff.row_end      <= 10'd240;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pas_front #(.LINE_WIDTH(LINE_WIDTH), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_mode        (req_tuser[0]),
      .in_frame_start (req_tuser[1]),
      .in_index       (req_tdata[8:0]),
      .in_color       (req_tdata[40:9]),
      .job_valid      (job_valid),
      .job_ready      (job_ready),
      .job            (job)
   );

   pas_emit #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
